@@ rtl/kipm_pkg.sv @@
// kipm_pkg: constants, status codes and word types for the keyed id map
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kipm_pkg;
  localparam int unsigned DefEntries = 1024;
  localparam int unsigned DefOrdinalBits = 24;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TargetW = 24;
  localparam int unsigned DomainW = 8;
  localparam int unsigned OrdinalW = 24;
  localparam int unsigned StatusW = 2;
  localparam logic [31:0] HashMult = 32'd2654435769;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [DomainW-1:0]  domain;
    logic [OrdinalW-1:0] ordinal;
    logic [TargetW-1:0]  new_target;
  } req_word_t;

  typedef struct packed {
    logic               found;
    logic [TargetW-1:0] result_target;
    status_t            status;
  } rsp_word_t;
endpackage
`default_nettype wire

@@ rtl/kipm_if.sv @@
// kipm_if: valid/ready channel carrying a generic payload
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface kipm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/kipm_ram.sv @@
// kipm_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module kipm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/kipm_hash.sv @@
// kipm_hash: registered multiplicative hash giving the home slot of a key
// depends on kipm_pkg
`timescale 1ns / 1ps
`default_nettype none
module kipm_hash #(
  parameter int unsigned ENTRIES = kipm_pkg::DefEntries
) (
  input  wire logic                            clk,
  input  wire logic [kipm_pkg::KeyW-1:0]       key,
  output logic      [$clog2(ENTRIES)-1:0]      slot
);
  import kipm_pkg::*;
  localparam int unsigned SW = $clog2(ENTRIES);
  logic [KeyW-1:0] prod;
  // low SW bits of the product mod 2^32 are the product mod 2^SW
  assign prod = key * HashMult;
  always_ff @(posedge clk) slot <= prod[SW-1:0];
endmodule
`default_nettype wire

@@ rtl/keyed_id_projection_map.sv @@
// keyed_id_projection_map: exact-match key to target map, linear probe table
// depends on kipm_pkg, kipm_if, kipm_ram, kipm_hash
//
// channel | dir | payload
// req     | in  | cmd, domain, ordinal, new_target
// rsp     | out | found, result_target, status
//
// an item is hashed, then each slot probed (1..ENTRIES of them) is read and then
// compared, with a write for a new insert, before the response; the table memory
// has a single read port: one compare per slot visited
// after reset a clearing pass over every slot zeroes the valid bits; ready is low
// ready is low while a word is in work or the response waits to be taken
`timescale 1ns / 1ps
`default_nettype none
module keyed_id_projection_map #(
  parameter int unsigned ENTRIES      = kipm_pkg::DefEntries,
  parameter int unsigned ORDINAL_BITS = kipm_pkg::DefOrdinalBits
) (
  input wire logic clk,
  input wire logic rst,
  kipm_if.sink     req,
  kipm_if.source   rsp
);
  import kipm_pkg::*;
  localparam int unsigned SW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = 1 + KeyW + TargetW;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_READ = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t              state;
  logic                cmd;
  logic [KeyW-1:0]     key;
  logic [TargetW-1:0]  tgt;
  logic [SW-1:0]       slot;
  logic [CW-1:0]       probes;
  logic [CW-1:0]       count;
  logic [SW-1:0]       home;
  logic [KeyW-1:0]     key_next;
  logic [RW-1:0]       rd;
  logic [RW-1:0]       wdata;
  logic                we;
  logic                found;
  logic [TargetW-1:0]  res;
  status_t             status;

  assign key_next = KeyW'({req.data.domain, ORDINAL_BITS'(req.data.ordinal)});

  // hash follows the incoming word so home is ready in the cycle after accept
  kipm_hash #(.ENTRIES(ENTRIES)) u_hash (.clk(clk), .key(key_next), .slot(home));

  // table word: valid bit, key, target
  assign we = (state == S_WR) || (state == S_CLR);
  assign wdata = (state == S_CLR) ? '0 : {1'b1, key, tgt};
  kipm_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .addr(slot), .wdata(wdata), .rdata(rd)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data.found = found;
  assign rsp.data.result_target = res;
  assign rsp.data.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      slot <= '0;
      count <= '0;
    end else begin
      case (state)
        S_CLR: begin
          slot <= slot + 1'b1;
          if (slot == SW'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          cmd <= req.data.cmd;
          key <= key_next;
          tgt <= req.data.new_target;
          state <= S_HASH;
        end
        S_HASH: begin
          slot <= home;
          probes <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (!rd[RW-1]) begin
            found <= 1'b0;
            res <= '0;
            if (cmd == CMD_LOOKUP) begin
              status <= ST_MISS;
              state <= S_OUT;
            end else if (count >= CW'(ENTRIES)) begin
              status <= ST_FULL;
              state <= S_OUT;
            end else begin
              status <= ST_INSERTED;
              state <= S_WR;
            end
          end else if (rd[KeyW+TargetW-1:TargetW] == key) begin
            found <= 1'b1;
            res <= rd[TargetW-1:0];
            status <= ST_PRESENT;
            state <= S_OUT;
          end else if (probes == CW'(ENTRIES - 1)) begin
            // whole table walked, key absent
            found <= 1'b0;
            res <= '0;
            status <= (cmd == CMD_LOOKUP) ? ST_MISS : ST_FULL;
            state <= S_OUT;
          end else begin
            slot <= (slot == SW'(ENTRIES - 1)) ? '0 : slot + 1'b1;
            probes <= probes + 1'b1;
            state <= S_READ;
          end
        end
        S_WR: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(ENTRIES))
    else $error("entry count above capacity");
  a_wr_grows: assert property (@(posedge clk) disable iff (rst)
      state == S_WR |=> count == $past(count) + 1'b1)
    else $error("insert did not bump count");
  a_ins_found: assert property (@(posedge clk) disable iff (rst)
      rsp.valid && status == ST_INSERTED |-> !found && res == '0)
    else $error("new insert reports found");
  a_present_found: assert property (@(posedge clk) disable iff (rst)
      rsp.valid |-> (found == (status == ST_PRESENT)))
    else $error("found flag disagrees with status");
endmodule
`default_nettype wire
